/* rtl/oid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package oid_pkg;

   localparam logic [6:0] ClsXor      = 7'd16;
   localparam logic [6:0] ClsMul      = 7'd12;
   localparam logic [6:0] ClsBr       = 7'd17;
   localparam logic [6:0] ClsBrPair0  = 7'd18;
   localparam logic [6:0] ClsBrPair3  = 7'd21;
   localparam logic [6:0] ClsBrLast   = 7'd24;
   localparam logic [6:0] ClsSob      = 7'd25;
   localparam logic [6:0] ClsJsr      = 7'd26;
   localparam logic [6:0] ClsEmt      = 7'd27;
   localparam logic [6:0] ClsTrap     = 7'd28;
   localparam logic [6:0] ClsJmp      = 7'd29;
   localparam logic [6:0] ClsSwab     = 7'd30;
   localparam logic [6:0] ClsClr      = 7'd31;
   localparam logic [6:0] ClsClrb     = 7'd32;
   localparam logic [6:0] ClsMfpi     = 7'd55;
   localparam logic [6:0] ClsMfpd     = 7'd56;
   localparam logic [6:0] ClsMtpi     = 7'd57;
   localparam logic [6:0] ClsMtpd     = 7'd58;
   localparam logic [6:0] ClsSxt      = 7'd59;
   localparam logic [6:0] ClsMark     = 7'd60;
   localparam logic [6:0] ClsCc       = 7'd61;
   localparam logic [6:0] ClsRts      = 7'd62;
   localparam logic [6:0] ClsSpl      = 7'd63;
   localparam logic [6:0] ClsRti      = 7'd64;
   localparam logic [6:0] ClsBpt      = 7'd65;
   localparam logic [6:0] ClsIot      = 7'd66;
   localparam logic [6:0] ClsRtt      = 7'd67;
   localparam logic [6:0] ClsHalt     = 7'd68;
   localparam logic [6:0] ClsWait     = 7'd69;
   localparam logic [6:0] ClsReset    = 7'd70;
   localparam logic [6:0] ClsReserved = 7'd71;
   localparam logic [6:0] ClsSrcLast  = 7'd11;
   localparam logic [6:0] ClsNone     = 7'h7F;

   localparam logic [6:0] Op9MulLo  = 7'o070;
   localparam logic [6:0] Op9MulHi  = 7'o074;
   localparam logic [6:0] Op9Br     = 7'o000;
   localparam logic [6:0] Op9PairLo = 7'o001;
   localparam logic [6:0] Op9PairHi = 7'o003;
   localparam logic [6:0] Op9HiLo   = 7'o100;
   localparam logic [6:0] Op9HiHi   = 7'o103;
   localparam logic [6:0] Op9Sob    = 7'o077;
   localparam logic [6:0] Op9Jsr    = 7'o004;
   localparam logic [6:0] Op9EmtTrap = 7'o104;

   localparam logic [9:0] Op6Jmp    = 10'o0001;
   localparam logic [9:0] Op6Cc     = 10'o0002;
   localparam logic [9:0] Op6Swab   = 10'o0003;
   localparam logic [9:0] Op6WordLo = 10'o0050;
   localparam logic [9:0] Op6WordHi = 10'o0063;
   localparam logic [9:0] Op6ByteLo = 10'o1050;
   localparam logic [9:0] Op6ByteHi = 10'o1063;
   localparam logic [9:0] Op6Mark   = 10'o0064;
   localparam logic [9:0] Op6Mfpi   = 10'o0065;
   localparam logic [9:0] Op6Mfpd   = 10'o1065;
   localparam logic [9:0] Op6Mtpi   = 10'o0066;
   localparam logic [9:0] Op6Mtpd   = 10'o1066;
   localparam logic [9:0] Op6Sxt    = 10'o0067;

   localparam logic [12:0] Op3Rts = 13'o00020;
   localparam logic [12:0] Op3Spl = 13'o00023;

   typedef struct packed {
      logic [6:0] op_class;
      logic [5:0] src_spec;
      logic [5:0] dst_spec;
      logic [2:0] reg_or_level;
      logic [7:0] branch_offset;
      logic       branch_sense;
      logic       cc_set;
      logic [3:0] cc_mask;
   } result_type;

   function automatic logic [6:0] top_group(input logic [3:0] code);
      logic [6:0] cls;
      case (code)
         4'd1:    cls = 7'd0;
         4'd2:    cls = 7'd2;
         4'd3:    cls = 7'd4;
         4'd4:    cls = 7'd6;
         4'd5:    cls = 7'd8;
         4'd6:    cls = 7'd10;
         4'd9:    cls = 7'd1;
         4'd10:   cls = 7'd3;
         4'd11:   cls = 7'd5;
         4'd12:   cls = 7'd7;
         4'd13:   cls = 7'd9;
         4'd14:   cls = 7'd11;
         default: cls = ClsNone;
      endcase
      return cls;
   endfunction

   function automatic logic [6:0] word_group(input logic [15:0] w);
      logic [6:0] cls;
      case (w)
         16'd0:   cls = ClsHalt;
         16'd1:   cls = ClsWait;
         16'd2:   cls = ClsRti;
         16'd3:   cls = ClsBpt;
         16'd4:   cls = ClsIot;
         16'd5:   cls = ClsReset;
         16'd6:   cls = ClsRtt;
         default: cls = ClsReserved;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

/* rtl/octal_isa_instruction_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Accepted when
// input     start, busy, req_instr_word     start high and busy low at a clock edge
// result    rsp_strobe, rsp_*               rsp_strobe high at a clock edge
//
// An item is accepted every cycle outside reset. It is held in the input
// register, then one pass of decode logic writes its result into the result
// register. Each result is shown for one cycle with rsp_strobe.
// Reset is synchronous and clears both valid flags; busy is high during reset.
// The receiver cannot stall, so busy never rises outside reset.

module octal_isa_instruction_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_instr_word,
   output logic             rsp_strobe,
   output logic [6:0]       rsp_op_class,
   output logic [5:0]       rsp_src_spec,
   output logic [5:0]       rsp_dst_spec,
   output logic [2:0]       rsp_reg_or_level,
   output logic [7:0]       rsp_branch_offset,
   output logic             rsp_branch_sense,
   output logic             rsp_cc_set,
   output logic [3:0]       rsp_cc_mask
);

   logic                valid_in;
   logic                valid_ff;
   logic [15:0]         instr_ff;
   logic [6:0]          op_class;
   oid_pkg::result_type result_in;
   oid_pkg::result_type result_ff;
   logic                rsp_valid_ff;

   assign busy     = reset;
   assign valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         instr_ff <= req_instr_word;
      end
      if (valid_ff) begin
         result_ff <= result_in;
      end
   end

   oid_classify u_classify (
      .instr_word (instr_ff),
      .op_class   (op_class)
   );

   oid_fields u_fields (
      .instr_word (instr_ff),
      .op_class   (op_class),
      .result     (result_in)
   );

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_op_class      = result_ff.op_class;
   assign rsp_src_spec      = result_ff.src_spec;
   assign rsp_dst_spec      = result_ff.dst_spec;
   assign rsp_reg_or_level  = result_ff.reg_or_level;
   assign rsp_branch_offset = result_ff.branch_offset;
   assign rsp_branch_sense  = result_ff.branch_sense;
   assign rsp_cc_set        = result_ff.cc_set;
   assign rsp_cc_mask       = result_ff.cc_mask;

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (rsp_strobe == $past(valid_ff)))
      else $error("Result strobe does not follow the input register.");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_op_class <= oid_pkg::ClsReserved))
      else $error("Operation number out of range.");

   a_reserved_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_op_class == oid_pkg::ClsReserved) |->
      (rsp_src_spec == 6'd0 && rsp_dst_spec == 6'd0 && rsp_reg_or_level == 3'd0 &&
       rsp_branch_offset == 8'd0 && !rsp_branch_sense && !rsp_cc_set &&
       rsp_cc_mask == 4'd0))
      else $error("Reserved item carries nonzero fields.");

   a_cc_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_op_class != oid_pkg::ClsCc) |->
      (!rsp_cc_set && rsp_cc_mask == 4'd0))
      else $error("Condition-code fields set outside the condition-code class.");

   a_src_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_src_spec != 6'd0) |-> (rsp_op_class <= oid_pkg::ClsSrcLast))
      else $error("Source field set for a class without a source operand.");

endmodule

`default_nettype wire

/* rtl/oid_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module oid_classify (
   input  wire logic [15:0] instr_word,
   output logic [6:0]       op_class
);

   logic [6:0]  o9;
   logic [9:0]  o6;
   logic [12:0] o3;
   logic [6:0]  top_cls;
   logic [9:0]  word_diff;
   logic [9:0]  byte_diff;

   assign o9        = instr_word[15:9];
   assign o6        = instr_word[15:6];
   assign o3        = instr_word[15:3];
   assign top_cls   = oid_pkg::top_group(instr_word[15:12]);
   assign word_diff = o6 - oid_pkg::Op6WordLo;
   assign byte_diff = o6 - oid_pkg::Op6ByteLo;

   always_comb begin
      if (top_cls != oid_pkg::ClsNone) begin
         op_class = top_cls;
      end else if (o9 >= oid_pkg::Op9MulLo && o9 <= oid_pkg::Op9MulHi) begin
         op_class = oid_pkg::ClsMul + (o9 - oid_pkg::Op9MulLo);
      end else if (o9 == oid_pkg::Op9Br && instr_word[8]) begin
         op_class = oid_pkg::ClsBr;
      end else if (o9 >= oid_pkg::Op9PairLo && o9 <= oid_pkg::Op9PairHi) begin
         op_class = oid_pkg::ClsBrPair0 + (o9 - oid_pkg::Op9PairLo);
      end else if (o9 >= oid_pkg::Op9HiLo && o9 <= oid_pkg::Op9HiHi) begin
         op_class = oid_pkg::ClsBrPair3 + (o9 - oid_pkg::Op9HiLo);
      end else if (o9 == oid_pkg::Op9Sob) begin
         op_class = oid_pkg::ClsSob;
      end else if (o9 == oid_pkg::Op9Jsr) begin
         op_class = oid_pkg::ClsJsr;
      end else if (o9 == oid_pkg::Op9EmtTrap) begin
         op_class = instr_word[8] ? oid_pkg::ClsTrap : oid_pkg::ClsEmt;
      end else if (o6 == oid_pkg::Op6Jmp) begin
         op_class = oid_pkg::ClsJmp;
      end else if (o6 == oid_pkg::Op6Swab) begin
         op_class = oid_pkg::ClsSwab;
      end else if (o6 >= oid_pkg::Op6WordLo && o6 <= oid_pkg::Op6WordHi) begin
         op_class = oid_pkg::ClsClr + {2'b00, word_diff[3:0], 1'b0};
      end else if (o6 >= oid_pkg::Op6ByteLo && o6 <= oid_pkg::Op6ByteHi) begin
         op_class = oid_pkg::ClsClrb + {2'b00, byte_diff[3:0], 1'b0};
      end else if (o6 == oid_pkg::Op6Mfpi) begin
         op_class = oid_pkg::ClsMfpi;
      end else if (o6 == oid_pkg::Op6Mfpd) begin
         op_class = oid_pkg::ClsMfpd;
      end else if (o6 == oid_pkg::Op6Mtpi) begin
         op_class = oid_pkg::ClsMtpi;
      end else if (o6 == oid_pkg::Op6Mtpd) begin
         op_class = oid_pkg::ClsMtpd;
      end else if (o6 == oid_pkg::Op6Sxt) begin
         op_class = oid_pkg::ClsSxt;
      end else if (o6 == oid_pkg::Op6Mark) begin
         op_class = oid_pkg::ClsMark;
      end else if (o6 == oid_pkg::Op6Cc && instr_word[5]) begin
         op_class = oid_pkg::ClsCc;
      end else if (o3 == oid_pkg::Op3Rts) begin
         op_class = oid_pkg::ClsRts;
      end else if (o3 == oid_pkg::Op3Spl) begin
         op_class = oid_pkg::ClsSpl;
      end else begin
         op_class = oid_pkg::word_group(instr_word);
      end
   end

endmodule

`default_nettype wire

/* rtl/oid_fields.sv */
`timescale 1ns / 1ps
`default_nettype none

module oid_fields (
   input  wire logic [15:0]        instr_word,
   input  wire logic [6:0]         op_class,
   output oid_pkg::result_type     result
);

   logic uses_src;
   logic uses_dst;
   logic uses_reg;
   logic uses_lvl;
   logic uses_off;
   logic uses_sns;
   logic uses_cc;

   always_comb begin
      uses_src = op_class <= oid_pkg::ClsSrcLast;
      uses_dst = op_class <= oid_pkg::ClsXor || op_class == oid_pkg::ClsSob ||
                 op_class == oid_pkg::ClsJsr ||
                 (op_class >= oid_pkg::ClsJmp && op_class <= oid_pkg::ClsMark);
      uses_reg = (op_class >= oid_pkg::ClsMul && op_class <= oid_pkg::ClsXor) ||
                 op_class == oid_pkg::ClsSob || op_class == oid_pkg::ClsJsr;
      uses_lvl = op_class == oid_pkg::ClsRts || op_class == oid_pkg::ClsSpl;
      uses_off = (op_class >= oid_pkg::ClsBr && op_class <= oid_pkg::ClsBrLast) ||
                 op_class == oid_pkg::ClsEmt || op_class == oid_pkg::ClsTrap;
      uses_sns = (op_class >= oid_pkg::ClsBrPair0 && op_class <= oid_pkg::ClsBrLast) ||
                 op_class == oid_pkg::ClsEmt || op_class == oid_pkg::ClsTrap;
      uses_cc  = op_class == oid_pkg::ClsCc;

      result.op_class      = op_class;
      result.src_spec      = uses_src ? instr_word[11:6] : 6'd0;
      result.dst_spec      = uses_dst ? instr_word[5:0] : 6'd0;
      result.reg_or_level  = uses_reg ? instr_word[8:6] :
                             (uses_lvl ? instr_word[2:0] : 3'd0);
      result.branch_offset = uses_off ? instr_word[7:0] : 8'd0;
      result.branch_sense  = uses_sns ? instr_word[8] : 1'b0;
      result.cc_set        = uses_cc ? instr_word[4] : 1'b0;
      result.cc_mask       = uses_cc ? instr_word[3:0] : 4'd0;
   end

endmodule

`default_nettype wire
